FILE: rtl/pairwise_gaussian_composite_loglik_defines.svh
// assertion macros for the composite likelihood block
`ifndef PAIRWISE_GAUSSIAN_COMPOSITE_LOGLIK_DEFINES_SVH
`define PAIRWISE_GAUSSIAN_COMPOSITE_LOGLIK_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define PGCL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pgcl: same-cycle check failed");
// next-cycle implication
`define PGCL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pgcl: next-cycle check failed");
`else
`define PGCL_ASSERT_IMP(label, ante, cons)
`define PGCL_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/pgcl_pkg.sv
`timescale 1ns / 1ps
package pgcl_pkg;

  localparam int MAX_DIM     = 16;
  localparam int ADDR_W      = 8;
  localparam int STORE_DEPTH = 256;
  localparam int VAL_W       = 32;
  localparam int IDX_W       = 4;
  localparam int SUM_W       = 40;
  localparam int CFG_W       = 16;

  // arithmetic widths
  localparam int NUM_W  = 50;
  localparam int QSH    = 32;
  localparam int DEND_W = NUM_W + QSH;
  localparam int DSOR_W = 63;
  localparam int QUO_W  = 48;
  localparam int LN_W   = 24;
  localparam int T_W    = 50;

  localparam logic [QUO_W-1:0]         QUOT_CAP      = 48'h8000_0000_0000;
  localparam logic signed [VAL_W-1:0]  LIK_CONST_Q16 = 32'sd240894;
  localparam logic [31:0]              LN2_Q32       = 32'd2977044472;

  // input modes
  localparam logic [1:0] MODE_COV  = 2'd0;
  localparam logic [1:0] MODE_DATA = 2'd1;
  localparam logic [1:0] MODE_PAIR = 2'd2;

  // classified request kinds in the queue
  localparam logic [1:0] KIND_COV  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_PAIR = 2'd2;

  // configuration register indexes
  localparam logic [0:0] CFG_DATA_IS_MATRIX = 1'b0;
  localparam logic [0:0] CFG_PAIR_COUNT     = 1'b1;

  typedef struct packed {
    logic [1:0]              mode;
    logic [ADDR_W-1:0]       load_address;
    logic signed [VAL_W-1:0] load_value;
    logic [IDX_W-1:0]        first_index;
    logic [IDX_W-1:0]        second_index;
    logic                    last_pair;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] log_likelihood;
    logic                    bad_determinant;
  } out_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  value;
    logic [IDX_W-1:0]  first_idx;
    logic [IDX_W-1:0]  second_idx;
    logic              last_pair;
  } q_entry_t;

  typedef struct packed {
    logic             data_is_matrix;
    logic [CFG_W-1:0] pair_count;
  } cfg_t;

endpackage

FILE: rtl/pgcl_front.sv
`timescale 1ns / 1ps
module pgcl_front import pgcl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  in_item_t in_item,
  output logic     busy,
  input  logic     q_pop,
  output logic     q_valid,
  output q_entry_t q_entry
);

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  q_entry_t             q_mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                 push;
  logic                 take;
  logic [1:0]           kind;

  assign busy    = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign take    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_entry = q_mem_r[rd_ptr_r];

  // classify; mode three is taken and dropped
  always_comb begin
    kind = KIND_COV;
    push = 1'b0;
    unique case (in_item.mode)
      MODE_COV:  begin kind = KIND_COV;  push = take; end
      MODE_DATA: begin kind = KIND_DATA; push = take; end
      MODE_PAIR: begin kind = KIND_PAIR; push = take; end
      default:   begin kind = KIND_COV;  push = 1'b0; end
    endcase
  end

  always_comb begin
    unique case ({push, q_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (q_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= '{kind:       kind,
                             addr:       in_item.load_address,
                             value:      in_item.load_value,
                             first_idx:  in_item.first_index,
                             second_idx: in_item.second_index,
                             last_pair:  in_item.last_pair};
    end
  end

endmodule

FILE: rtl/pgcl_div.sv
`timescale 1ns / 1ps
module pgcl_div import pgcl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DEND_W-1:0] dend,
  input  logic [DSOR_W-1:0] dsor,
  output logic              done,
  output logic [QUO_W-1:0]  quo
);

  localparam int CNT_W = $clog2(DEND_W);

  logic              busy_r, done_r, ovf_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DEND_W-1:0] dend_r;
  logic [DSOR_W-1:0] dsor_r, rem_r;
  logic [QUO_W:0]    q_r;
  logic [DSOR_W:0]   rem_sh, rem_df;
  logic              ge;

  // restoring division, one quotient bit a cycle
  assign rem_sh = {rem_r, dend_r[DEND_W-1]};
  assign rem_df = rem_sh - {1'b0, dsor_r};
  assign ge     = (rem_sh >= {1'b0, dsor_r});

  assign done = done_r;
  assign quo  = (ovf_r || (q_r > {1'b0, QUOT_CAP})) ? QUOT_CAP : q_r[QUO_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == CNT_W'(DEND_W - 1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dend_r <= dend;
      dsor_r <= dsor;
      rem_r  <= '0;
      q_r    <= '0;
      ovf_r  <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      dend_r <= {dend_r[DEND_W-2:0], 1'b0};
      rem_r  <= ge ? rem_df[DSOR_W-1:0] : rem_sh[DSOR_W-1:0];
      ovf_r  <= ovf_r | q_r[QUO_W];
      q_r    <= {q_r[QUO_W-1:0], ge};
      cnt_r  <= cnt_r + 1'b1;
    end
  end

endmodule

FILE: rtl/pgcl_ln.sv
`timescale 1ns / 1ps
module pgcl_ln import pgcl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [DSOR_W-1:0]      det,
  output logic                   done,
  output logic signed [LN_W-1:0] ln
);

  localparam int K_W    = $clog2(DSOR_W);
  localparam int M_W    = 31;
  localparam int F_W    = 16;
  localparam int L2_W   = K_W + 1 + F_W;
  localparam int LNP_W  = L2_W + 33;

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_NORM = 3'd1;
  localparam logic [2:0] L_SQ   = 3'd2;
  localparam logic [2:0] L_MUL  = 3'd3;
  localparam logic [2:0] L_FIN  = 3'd4;

  logic [2:0]               st_r;
  logic                     done_r;
  logic [DSOR_W-1:0]        y_r;
  logic [K_W-1:0]           k_r;
  logic [M_W-1:0]           mant_r;
  logic [F_W-1:0]           frac_r;
  logic [3:0]               it_r;
  logic signed [LNP_W-1:0]  lprod_r, lsum;
  logic signed [LN_W-1:0]   ln_r;
  logic [2*M_W-1:0]         sq;
  logic [M_W:0]             y2;
  logic signed [K_W:0]      kexp;
  logic signed [L2_W-1:0]   l2;

  assign sq   = mant_r * mant_r;
  assign y2   = sq[2*M_W-1:M_W-1];
  assign kexp = $signed({1'b0, k_r}) - $signed((K_W+1)'(32));
  assign l2   = $signed({kexp, frac_r});
  assign lsum = lprod_r + $signed(LNP_W'(64'h8000_0000));

  assign done = done_r;
  assign ln   = ln_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= L_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        L_IDLE: if (start) st_r <= L_NORM;
        L_NORM: if (y_r[DSOR_W-1]) st_r <= L_SQ;
        L_SQ:   if (it_r == 4'd15) st_r <= L_MUL;
        L_MUL:  st_r <= L_FIN;
        L_FIN: begin
          st_r   <= L_IDLE;
          done_r <= 1'b1;
        end
        default: st_r <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      L_IDLE: begin
        y_r    <= det;
        k_r    <= K_W'(DSOR_W - 1);
        frac_r <= '0;
        it_r   <= '0;
      end
      L_NORM: begin
        if (y_r[DSOR_W-1]) begin
          mant_r <= y_r[DSOR_W-1 -: M_W];
        end else begin
          y_r <= {y_r[DSOR_W-2:0], 1'b0};
          k_r <= k_r - 1'b1;
        end
      end
      L_SQ: begin
        // square the mantissa, one bit of log2 per step
        if (y2[M_W]) begin
          mant_r <= y2[M_W:1];
          frac_r <= {frac_r[F_W-2:0], 1'b1};
        end else begin
          mant_r <= y2[M_W-1:0];
          frac_r <= {frac_r[F_W-2:0], 1'b0};
        end
        it_r <= it_r + 1'b1;
      end
      L_MUL:   lprod_r <= l2 * $signed({1'b0, LN2_Q32});
      L_FIN:   ln_r <= lsum[QSH +: LN_W];
      default: it_r <= '0;
    endcase
  end

endmodule

FILE: rtl/pgcl_back.sv
`timescale 1ns / 1ps
module pgcl_back import pgcl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  q_entry_t  q_entry,
  output logic      q_pop,
  output logic      out_strobe,
  output out_item_t out_result
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_READ  = 4'd1;
  localparam logic [3:0] ST_MUL   = 4'd2;
  localparam logic [3:0] ST_MWAIT = 4'd3;
  localparam logic [3:0] ST_CHECK = 4'd4;
  localparam logic [3:0] ST_DIVQ  = 4'd5;
  localparam logic [3:0] ST_TERM  = 4'd6;
  localparam logic [3:0] ST_DIVT  = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  localparam logic [2:0] STEP_XII = 3'd0;
  localparam logic [2:0] STEP_XIJ = 3'd1;
  localparam logic [2:0] STEP_XJJ = 3'd2;
  localparam logic [2:0] STEP_DA  = 3'd3;
  localparam logic [2:0] STEP_DB  = 3'd4;
  localparam logic [2:0] STEP_QA  = 3'd5;
  localparam logic [2:0] STEP_QB  = 3'd6;
  localparam logic [2:0] STEP_QC  = 3'd7;

  localparam logic signed [T_W-1:0] SUM_HI = 50'sh7F_FFFF_FFFF;
  localparam logic signed [T_W-1:0] SUM_LO = -50'sh80_0000_0000;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [47:0] v);
    if (v > 48'sh7FFF_FFFF) sat32 = 32'sh7FFF_FFFF;
    else if (v < -48'sh8000_0000) sat32 = 32'sh8000_0000;
    else sat32 = v[VAL_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] pair_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    pair_addr = ADDR_W'(int'(r) * MAX_DIM + int'(c));
  endfunction

  logic [VAL_W-1:0] cov_mem [STORE_DEPTH];
  logic [VAL_W-1:0] data_mem [STORE_DEPTH];
  logic [VAL_W-1:0] cov_q_r, data_q_r;
  logic [ADDR_W-1:0] cov_ra, data_ra;

  logic [3:0] state_r, state_nxt;
  logic [1:0] rcnt_r;
  logic [2:0] mstep_r, ptag_r;
  logic       pvld_r, qd_r, ld_r, err_r, out_strobe_r, last_r;
  logic [IDX_W-1:0] i_r, j_r;
  logic signed [VAL_W-1:0] s11_r, s12_r, s22_r, x11_r, x12_r, x22_r, opa, opb;
  logic signed [63:0] mul_p, prod_r, det_r;
  logic signed [47:0] prod_sh;
  logic signed [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] num_mag;
  logic [QUO_W-1:0] qm_r;
  logic signed [LN_W-1:0] ln_r;
  logic signed [T_W-1:0] t_r, t_nxt, qs, term, sum_ext;
  logic [T_W-1:0] t_mag;
  logic signed [SUM_W-1:0] sum_r;
  out_item_t out_result_r;

  logic cov_we, data_we, pair_take, det_pos, num_neg, both_done;
  logic [CFG_W-1:0] pc1;
  logic [CFG_W:0]   pc_x2;

  logic              div_start, div_done;
  logic [DEND_W-1:0] div_dend;
  logic [DSOR_W-1:0] div_dsor;
  logic [QUO_W-1:0]  div_quo;
  logic              ln_start, ln_done;
  logic signed [LN_W-1:0] ln_q;

  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign cov_we    = q_pop && (q_entry.kind == KIND_COV);
  assign data_we   = q_pop && (q_entry.kind == KIND_DATA);
  assign pair_take = q_pop && (q_entry.kind == KIND_PAIR);

  always_comb begin
    unique case (rcnt_r)
      2'd0: begin
        cov_ra  = pair_addr(i_r, i_r);
        data_ra = cfg.data_is_matrix ? pair_addr(i_r, i_r) : ADDR_W'(i_r);
      end
      2'd1: begin
        cov_ra  = pair_addr(i_r, j_r);
        data_ra = cfg.data_is_matrix ? pair_addr(i_r, j_r) : ADDR_W'(j_r);
      end
      default: begin
        cov_ra  = pair_addr(j_r, j_r);
        data_ra = pair_addr(j_r, j_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cov_we) cov_mem[q_entry.addr] <= q_entry.value;
    if (data_we) data_mem[q_entry.addr] <= q_entry.value;
    cov_q_r  <= cov_mem[cov_ra];
    data_q_r <= data_mem[data_ra];
  end

  // shared multiplier schedule
  always_comb begin
    unique case (mstep_r)
      STEP_XII: begin opa = x11_r; opb = x11_r; end
      STEP_XIJ: begin opa = x11_r; opb = x12_r; end
      STEP_XJJ: begin opa = x12_r; opb = x12_r; end
      STEP_DA:  begin opa = s11_r; opb = s22_r; end
      STEP_DB:  begin opa = s12_r; opb = s12_r; end
      STEP_QA:  begin opa = s22_r; opb = x11_r; end
      STEP_QB:  begin opa = s12_r; opb = x12_r; end
      default:  begin opa = s11_r; opb = x22_r; end
    endcase
  end

  assign mul_p   = opa * opb;
  assign prod_sh = prod_r[63:16];

  assign det_pos   = !det_r[63] && (det_r != '0);
  assign num_neg   = num_r[NUM_W-1];
  assign num_mag   = num_neg ? NUM_W'(-num_r) : NUM_W'(num_r);
  assign both_done = (qd_r || div_done) && (ld_r || ln_done);

  assign qs    = num_neg ? -$signed({2'b00, qm_r}) : $signed({2'b00, qm_r});
  assign t_nxt = T_W'(LIK_CONST_Q16) + T_W'(ln_r) + qs;
  assign t_mag = t_nxt[T_W-1] ? T_W'(-t_nxt) : T_W'(t_nxt);

  assign pc1   = (cfg.pair_count == '0) ? CFG_W'(1) : cfg.pair_count;
  assign pc_x2 = {pc1, 1'b0};

  assign term    = t_r[T_W-1] ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
  assign sum_ext = T_W'(sum_r) + term;

  assign div_start = ((state_r == ST_CHECK) && det_pos) || (state_r == ST_TERM);
  assign div_dend  = (state_r == ST_TERM) ? DEND_W'(t_mag) : {num_mag, QSH'(0)};
  assign div_dsor  = (state_r == ST_TERM) ? DSOR_W'(pc_x2) : det_r[DSOR_W-1:0];
  assign ln_start  = (state_r == ST_CHECK) && det_pos;

  pgcl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dend  (div_dend),
    .dsor  (div_dsor),
    .done  (div_done),
    .quo   (div_quo)
  );

  pgcl_ln u_ln (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ln_start),
    .det   (det_r[DSOR_W-1:0]),
    .done  (ln_done),
    .ln    (ln_q)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (pair_take) state_nxt = ST_READ;
      ST_READ:  if (rcnt_r == 2'd3) state_nxt = ST_MUL;
      ST_MUL:   if (mstep_r == STEP_QC) state_nxt = ST_MWAIT;
      ST_MWAIT: state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = det_pos ? ST_DIVQ : ST_DONE;
      ST_DIVQ:  if (both_done) state_nxt = ST_TERM;
      ST_TERM:  state_nxt = ST_DIVT;
      ST_DIVT:  if (div_done) state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pvld_r       <= 1'b0;
      qd_r         <= 1'b0;
      ld_r         <= 1'b0;
      sum_r        <= '0;
      err_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pvld_r       <= (state_r == ST_MUL);
      out_strobe_r <= (state_r == ST_DONE) && last_r;
      if (state_r == ST_CHECK) begin
        qd_r <= 1'b0;
        ld_r <= 1'b0;
        if (!det_pos) err_r <= 1'b1;
      end
      if (state_r == ST_DIVQ) begin
        if (div_done) qd_r <= 1'b1;
        if (ln_done) ld_r <= 1'b1;
      end
      if ((state_r == ST_DIVT) && div_done) begin
        if (sum_ext > SUM_HI) sum_r <= SUM_HI[SUM_W-1:0];
        else if (sum_ext < SUM_LO) sum_r <= SUM_LO[SUM_W-1:0];
        else sum_r <= sum_ext[SUM_W-1:0];
      end
      if ((state_r == ST_DONE) && last_r) begin
        sum_r <= '0;
        err_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    ptag_r <= mstep_r;
    if (pair_take) begin
      i_r    <= q_entry.first_idx;
      j_r    <= q_entry.second_idx;
      last_r <= q_entry.last_pair;
      rcnt_r <= '0;
    end
    if (state_r == ST_READ) begin
      rcnt_r <= rcnt_r + 1'b1;
      unique case (rcnt_r)
        2'd1: begin s11_r <= cov_q_r; x11_r <= data_q_r; end
        2'd2: begin s12_r <= cov_q_r; x12_r <= data_q_r; end
        2'd3: begin
          s22_r   <= cov_q_r;
          x22_r   <= data_q_r;
          mstep_r <= cfg.data_is_matrix ? STEP_DA : STEP_XII;
        end
        default: ;
      endcase
    end
    if (state_r == ST_MUL) mstep_r <= mstep_r + 1'b1;
    if (pvld_r) begin
      unique case (ptag_r)
        STEP_XII: x11_r <= sat32(prod_sh);
        STEP_XIJ: x12_r <= sat32(prod_sh);
        STEP_XJJ: x22_r <= sat32(prod_sh);
        STEP_DA:  det_r <= prod_r;
        STEP_DB:  det_r <= det_r - prod_r;
        STEP_QA:  num_r <= NUM_W'(prod_sh);
        STEP_QB:  num_r <= num_r - NUM_W'($signed({prod_sh, 1'b0}));
        default:  num_r <= num_r + NUM_W'(prod_sh);
      endcase
    end
    if ((state_r == ST_DIVQ) && div_done) qm_r <= div_quo;
    if ((state_r == ST_DIVQ) && ln_done) ln_r <= ln_q;
    if (state_r == ST_TERM) t_r <= t_nxt;
    if (state_r == ST_DONE) begin
      out_result_r <= '{log_likelihood: sum_r, bad_determinant: err_r};
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_result = out_result_r;

endmodule

FILE: rtl/pairwise_gaussian_composite_loglik.sv
`timescale 1ns / 1ps
// pairwise bivariate normal composite log likelihood, Q16.16 in, Q24.16 out
// input channel: in_item is taken on a clock edge with start high and busy low;
//   mode 0 loads a covariance entry, mode 1 a data entry, mode 2 runs a pair,
//   mode 3 is taken and dropped
// a four-entry request queue parts the front from the back; busy is high only
//   while that queue is full, so loads stream in one a cycle until it fills
// the back takes loads from the queue while idle and no new request until a pair
//   is done; a pair's time is set mostly by the bit-serial divider, which runs
//   82 steps for the quotient of the quadratic form and again for the scaling by
//   two times pair_count (zero taken as one), and is longer with vector data; a
//   pair whose determinant is not positive skips both divisions
// the log unit normalises and squares alongside the first division
// a result is raised only on a pair marked last: out_strobe is high for one
//   cycle with out_result; the receiver cannot hold it off, and the sum and
//   flag clear
// cfg port: cfg_we writes register cfg_index with cfg_wdata at the clock edge;
//   write only while the block is idle
// synchronous reset clears the queue, the sequencer, the running sum and the
//   error flag and sets data_is_matrix and pair_count to one; stores not cleared
`include "pairwise_gaussian_composite_loglik_defines.svh"
module pairwise_gaussian_composite_loglik import pgcl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  // request channel
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_item,
  // result channel
  output logic             out_strobe,
  output out_item_t        out_result,
  // configuration port
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  // configuration registers
  logic             data_is_matrix_r;
  logic [CFG_W-1:0] pair_count_r;
  cfg_t             cfg;

  // queue between front and back
  logic     q_pop;
  logic     q_valid;
  q_entry_t q_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_is_matrix_r <= 1'b1;
      pair_count_r     <= CFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DATA_IS_MATRIX: data_is_matrix_r <= cfg_wdata[0];
        CFG_PAIR_COUNT:     pair_count_r     <= cfg_wdata;
        default:            pair_count_r     <= pair_count_r;
      endcase
    end
  end

  assign cfg = '{data_is_matrix: data_is_matrix_r, pair_count: pair_count_r};

  // front: takes requests, classifies by mode, queues all but mode three
  pgcl_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_item),
    .busy    (busy),
    .q_pop   (q_pop),
    .q_valid (q_valid),
    .q_entry (q_entry)
  );

  // back: stores, shared multiplier, divider and log unit, accumulator
  pgcl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop),
    .out_strobe (out_strobe),
    .out_result (out_result)
  );

  // a pair walks the sequencer from idle to done, so results never come back to back
  `PGCL_ASSERT_NEXT(a_strobe_single, out_strobe, !out_strobe)
  // the back only pops when the queue holds a request
  `PGCL_ASSERT_IMP(a_pop_valid, q_pop, q_valid)
  // a full queue always offers a request to the back
  `PGCL_ASSERT_IMP(a_busy_queue, busy, q_valid)

endmodule

FILE: test/pairwise_gaussian_composite_loglik_test.sv
`timescale 1ns / 1ps
module pairwise_gaussian_composite_loglik_test;
  import pgcl_pkg::*;

  localparam int  LIMIT_CYCLES = 3000000;
  localparam int  SETTLE       = 260;   // covers a pair still running in the back end
  localparam int  RAND_ITEMS   = 1450;

  localparam longint LIK_C     = 64'sd240894;
  localparam longint LN2_C     = 64'sd2977044472;
  localparam longint QCAP      = 64'sd140737488355328;
  localparam longint SUM_HI    = (64'sd1 <<< 39) - 1;
  localparam longint SUM_LO    = -(64'sd1 <<< 39);

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  in_item_t         in_item = '0;
  logic             out_strobe;
  out_item_t        out_result;
  logic             cfg_we = 1'b0;
  logic [0:0]       cfg_index = CFG_DATA_IS_MATRIX;
  logic [CFG_W-1:0] cfg_wdata = '0;

  pairwise_gaussian_composite_loglik u_dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_result(out_result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // model copy of the block
  logic signed [31:0] cov_mem [256];
  logic signed [31:0] dat_mem [256];
  bit                 cov_set [256];
  bit                 dat_set [256];
  longint             lik_sum;
  bit                 det_err;
  bit                 mdl_matrix;
  logic [15:0]        mdl_pairs;

  out_item_t          likelihood_q[$];
  int                 fails = 0;
  int                 cycles = 0;
  int                 sent = 0;

  // a directed row may carry its expected result typed in
  logic               row_typed = 1'b0;
  out_item_t          row_result = '0;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t result;
  } row_t;
  row_t rows[$];

  function automatic longint floor16(longint v);
    return v >>> 16;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // ln of a positive Q32.32 value, Q16.16 result
  function automatic longint ln_det(logic [63:0] d);
    int          k;
    logic [63:0] y;
    longint      frac;
    longint      l2;
    k = 63;
    frac = 0;
    while (d[k] == 1'b0) k--;
    y = (k >= 30) ? (d >> (k - 30)) : (d << (30 - k));
    for (int n = 0; n < 16; n++) begin
      y = (y * y) >> 30;
      frac = frac << 1;
      if (y >= (64'd2 << 30)) begin
        y = y >> 1;
        frac = frac | 1;
      end
    end
    l2 = longint'(k - 32) * 65536 + frac;
    return (l2 * LN2_C + (64'sd1 <<< 31)) >>> 32;
  endfunction

  // one pair folded into the running likelihood
  function automatic void fold_pair(logic [3:0] i, logic [3:0] j);
    longint       s11, s12, s22, x11, x12, x22, xi, xj, det, num, t, term, dv;
    logic [111:0] quo;
    longint       qm, mag;
    s11 = longint'(cov_mem[{i, i}]);
    s12 = longint'(cov_mem[{i, j}]);
    s22 = longint'(cov_mem[{j, j}]);
    if (mdl_matrix) begin
      x11 = longint'(dat_mem[{i, i}]);
      x12 = longint'(dat_mem[{i, j}]);
      x22 = longint'(dat_mem[{j, j}]);
    end else begin
      xi = longint'(dat_mem[{4'd0, i}]);
      xj = longint'(dat_mem[{4'd0, j}]);
      x11 = clip(floor16(xi * xi), -64'sd2147483648, 64'sd2147483647);
      x12 = clip(floor16(xi * xj), -64'sd2147483648, 64'sd2147483647);
      x22 = clip(floor16(xj * xj), -64'sd2147483648, 64'sd2147483647);
    end
    det = s11 * s22 - s12 * s12;
    if (det <= 0) begin
      det_err = 1'b1;
      return;
    end
    num = floor16(s22 * x11) - 2 * floor16(s12 * x12) + floor16(s11 * x22);
    mag = num < 0 ? -num : num;
    quo = (112'(mag) << 32) / 112'(det);
    qm = (quo > 112'(QCAP)) ? QCAP : longint'(quo);
    t = LIK_C + ln_det(det) + (num < 0 ? -qm : qm);
    dv = 2 * ((mdl_pairs == 16'd0) ? 64'sd1 : longint'({48'd0, mdl_pairs}));
    term = t / dv;  // truncates toward zero
    lik_sum = clip(lik_sum + term, SUM_LO, SUM_HI);
  endfunction

  // request and result monitor, plus model register writes
  always @(posedge clk) begin
    out_item_t exp_r;
    out_item_t got;
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_index == CFG_DATA_IS_MATRIX) mdl_matrix <= cfg_wdata[0];
        else mdl_pairs <= cfg_wdata;
      end
      if (start && !busy) begin
        case (in_item.mode)
          MODE_COV:  cov_mem[in_item.load_address] = in_item.load_value;
          MODE_DATA: dat_mem[in_item.load_address] = in_item.load_value;
          MODE_PAIR: begin
            fold_pair(in_item.first_index, in_item.second_index);
            if (in_item.last_pair) begin
              exp_r.log_likelihood = lik_sum[39:0];
              exp_r.bad_determinant = det_err;
              likelihood_q.push_back(row_typed ? row_result : exp_r);
              lik_sum = 0;
              det_err = 1'b0;
            end
          end
          default: ;  // mode three is dropped
        endcase
      end
      if (out_strobe) begin
        got = out_result;
        if (likelihood_q.size() == 0) begin
          $error("result with nothing expected: log_likelihood %h", got.log_likelihood);
          fails++;
        end else begin
          exp_r = likelihood_q.pop_front();
          if (got.log_likelihood !== exp_r.log_likelihood) begin
            $error("log_likelihood expected %h actual %h",
                   exp_r.log_likelihood, got.log_likelihood);
            fails++;
          end
          if (got.bad_determinant !== exp_r.bad_determinant) begin
            $error("bad_determinant expected %b actual %b",
                   exp_r.bad_determinant, got.bad_determinant);
            fails++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // one request with a random hold-off ahead of it
  task automatic send_request(in_item_t it, bit typed, out_item_t res);
    int gap;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;  // stretches of back to back requests
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_item <= it;
    row_typed <= typed;
    row_result <= res;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic write_reg(logic [0:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    start <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // drain outstanding results, then let the back end settle
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (likelihood_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic in_item_t noise_item();
    in_item_t it;
    it.mode = 2'($urandom);
    it.load_address = 8'($urandom);
    it.load_value = $urandom;
    it.first_index = 4'($urandom);
    it.second_index = 4'($urandom);
    it.last_pair = 1'($urandom);
    return it;
  endfunction

  function automatic logic [31:0] diag_value();
    case ($urandom_range(0, 7))
      0:       return $urandom;
      1:       return -$urandom_range(0, 1 << 18);
      2:       return $urandom_range(32'h4000_0000, 32'h7fff_ffff);
      default: return $urandom_range(1, 1 << 20);
    endcase
  endfunction

  function automatic logic [31:0] other_value();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      default: return $urandom_range(0, 1 << 19) - (1 << 18);
    endcase
  endfunction

  task automatic load_entry(bit to_cov, logic [7:0] addr, logic [31:0] val);
    in_item_t it;
    it = noise_item();
    it.mode = to_cov ? MODE_COV : MODE_DATA;
    it.load_address = addr;
    it.load_value = val;
    if (to_cov) cov_set[addr] = 1'b1;
    else dat_set[addr] = 1'b1;
    send_request(it, 1'b0, '0);
  endtask

  function automatic void add_row(logic [1:0] m, logic [7:0] a, logic [31:0] v,
                                  logic [3:0] i, logic [3:0] j, bit last,
                                  bit typed, logic [39:0] ll, bit bad);
    row_t r;
    r.item = '{m, a, v, i, j, last};
    r.typed = typed;
    r.result = '{ll, bad};
    rows.push_back(r);
  endfunction

  // current data layout as held by the model
  function automatic bit u_dut_matrix_mode();
    return mdl_matrix;
  endfunction

  initial begin
    in_item_t   it;
    int         npairs;
    logic [3:0] pi, pj;
    logic [15:0] pc;
    bit         fresh;

    lik_sum = 0;
    det_err = 1'b0;
    mdl_matrix = 1'b1;
    mdl_pairs = 16'd1;

    // zeroed 2x2 corner: determinant zero raises the error
    add_row(MODE_COV,  8'd0,  32'd0, 0, 0, 1, 0, 0, 0);
    add_row(MODE_COV,  8'd1,  32'd0, 0, 0, 0, 0, 0, 0);
    add_row(MODE_COV,  8'd17, 32'd0, 0, 0, 1, 0, 0, 0);
    add_row(MODE_DATA, 8'd0,  32'd0, 0, 0, 0, 0, 0, 0);
    add_row(MODE_DATA, 8'd1,  32'd0, 0, 0, 1, 0, 0, 0);
    add_row(MODE_DATA, 8'd17, 32'd0, 0, 0, 0, 0, 0, 0);
    add_row(MODE_PAIR, 8'hff, 32'hffff_ffff, 0, 1, 1, 1, 40'd0, 1'b1);
    // largest diagonal against most negative covariance: determinant negative
    add_row(MODE_COV,  8'd0,  32'h7fff_ffff, 0, 0, 0, 0, 0, 0);
    add_row(MODE_COV,  8'd17, 32'h7fff_ffff, 0, 0, 0, 0, 0, 0);
    add_row(MODE_COV,  8'd1,  32'h8000_0000, 0, 0, 0, 0, 0, 0);
    add_row(MODE_PAIR, 8'd0,  32'd0, 0, 1, 1, 1, 40'd0, 1'b1);
    // large positive determinant with extreme data
    add_row(MODE_COV,  8'd1,  32'd0, 0, 0, 0, 0, 0, 0);
    add_row(MODE_DATA, 8'd0,  32'h7fff_ffff, 0, 0, 0, 0, 0, 0);
    add_row(MODE_DATA, 8'd17, 32'h8000_0000, 0, 0, 0, 0, 0, 0);
    add_row(MODE_PAIR, 8'd0,  32'd0, 0, 1, 1, 0, 0, 0);
    // tiny determinant: quotient caps and the sum saturates high, then low
    add_row(MODE_COV,  8'd0,  32'd1, 0, 0, 0, 0, 0, 0);
    add_row(MODE_COV,  8'd17, 32'd1, 0, 0, 0, 0, 0, 0);
    add_row(MODE_DATA, 8'd0,  32'h7fff_ffff, 0, 0, 0, 0, 0, 0);
    add_row(MODE_DATA, 8'd17, 32'h7fff_ffff, 0, 0, 0, 0, 0, 0);
    add_row(MODE_PAIR, 8'd0,  32'd0, 0, 1, 1, 1, 40'h7f_ffff_ffff, 1'b0);
    add_row(MODE_DATA, 8'd0,  32'h8000_0000, 0, 0, 0, 0, 0, 0);
    add_row(MODE_DATA, 8'd17, 32'h8000_0000, 0, 0, 0, 0, 0, 0);
    add_row(MODE_PAIR, 8'd0,  32'd0, 0, 1, 1, 1, 40'h80_0000_0000, 1'b0);
    // mode three dropped, top corner: a pair with itself is singular
    add_row(2'd3,      8'd0,  32'd0, 0, 1, 1, 0, 0, 0);
    add_row(MODE_COV,  8'd255, 32'h0001_0000, 0, 0, 0, 0, 0, 0);
    add_row(MODE_DATA, 8'd255, 32'h0001_0000, 0, 0, 0, 0, 0, 0);
    add_row(MODE_PAIR, 8'd0,  32'd0, 15, 15, 1, 1, 40'd0, 1'b1);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[r]) begin
      if (rows[r].item.mode == MODE_COV) cov_set[rows[r].item.load_address] = 1'b1;
      if (rows[r].item.mode == MODE_DATA) dat_set[rows[r].item.load_address] = 1'b1;
      send_request(rows[r].item, rows[r].typed, rows[r].result);
    end
    drain();

    // random phases: a fresh setting, then a well-formed run of pairs
    while (sent < RAND_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       pc = 16'hffff;
        1:       pc = 16'd0;
        2:       pc = 16'd1;
        default: pc = 16'($urandom_range(1, 8));
      endcase
      write_reg(CFG_DATA_IS_MATRIX, 16'($urandom_range(0, 1)));
      write_reg(CFG_PAIR_COUNT, pc);
      npairs = $urandom_range(1, 6);
      for (int k = 0; k < npairs; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          it = noise_item();
          if (it.mode == MODE_PAIR) it.mode = 2'd3;
          if (it.mode == MODE_COV) cov_set[it.load_address] = 1'b1;
          if (it.mode == MODE_DATA) dat_set[it.load_address] = 1'b1;
          send_request(it, 1'b0, '0);
        end
        pi = 4'($urandom);
        pj = ($urandom_range(0, 9) == 0) ? pi : 4'($urandom);
        fresh = $urandom_range(0, 1);
        if (fresh || !cov_set[{pi, pi}]) load_entry(1, {pi, pi}, diag_value());
        if (fresh || !cov_set[{pj, pj}]) load_entry(1, {pj, pj}, diag_value());
        if (fresh || !cov_set[{pi, pj}]) load_entry(1, {pi, pj}, other_value());
        if (u_dut_matrix_mode()) begin
          if (fresh || !dat_set[{pi, pi}]) load_entry(0, {pi, pi}, other_value());
          if (fresh || !dat_set[{pj, pj}]) load_entry(0, {pj, pj}, other_value());
          if (fresh || !dat_set[{pi, pj}]) load_entry(0, {pi, pj}, other_value());
        end else begin
          if (fresh || !dat_set[{4'd0, pi}]) load_entry(0, {4'd0, pi}, other_value());
          if (fresh || !dat_set[{4'd0, pj}]) load_entry(0, {4'd0, pj}, other_value());
        end
        it = noise_item();
        it.mode = MODE_PAIR;
        it.first_index = pi;
        it.second_index = pj;
        it.last_pair = (k == npairs - 1);
        send_request(it, 1'b0, '0);
      end
      drain();
    end

    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
